// ----- rtl/thp_pkg.sv -----
// Package for the Teredo header parser: shared constants and types.
// No dependencies; used by every other file of the block but thp_if.
package thp_pkg;

  // Datagram and header sizes
  localparam int unsigned MaxPacketBytes    = 65535;
  localparam int unsigned AuthFixedBytes    = 13;
  localparam int unsigned NonceConfirmBytes = 9;
  localparam int unsigned OriginBytes       = 8;

  // Configuration register indexes
  localparam logic [1:0] CfgAuthTypeCode   = 2'd0;
  localparam logic [1:0] CfgOriginTypeCode = 2'd1;
  localparam logic [1:0] CfgMinPacketLen   = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  AuthTypeReset   = 8'd1;
  localparam logic [7:0]  OriginTypeReset = 8'd0;
  localparam logic [15:0] MinLenReset     = 16'd40;

  // Live configuration seen by the parser
  typedef struct packed {
    logic [7:0]  auth_type_code;
    logic [7:0]  origin_type_code;
    logic [15:0] min_packet_length;
  } cfg_t;

  // One registered input item
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } byte_item_t;

endpackage

// ----- rtl/thp_if.sv -----
// Channel interfaces of the Teredo header parser: input bytes, verdicts, register writes.
// No dependencies.
interface thp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface thp_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        auth_present;
  logic        origin_present;
  logic [63:0] nonce_value;
  logic [7:0]  confirm_byte;
  logic [15:0] origin_port_raw;
  logic [31:0] origin_addr_raw;
  logic [9:0]  payload_offset;
  logic [15:0] payload_length;
  modport source (output valid, output status, output auth_present, output origin_present,
                  output nonce_value, output confirm_byte, output origin_port_raw,
                  output origin_addr_raw, output payload_offset, output payload_length,
                  input ready);
  modport sink   (input valid, input status, input auth_present, input origin_present,
                  input nonce_value, input confirm_byte, input origin_port_raw,
                  input origin_addr_raw, input payload_offset, input payload_length,
                  output ready);
endinterface

interface thp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/thp_cfg_regs.sv -----
// Configuration registers of the Teredo header parser.
// Depends on thp_pkg and thp_cfg_if.
module thp_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  thp_cfg_if.sink        cfg_i,
  output thp_pkg::cfg_t  cfg_o
);

  logic [7:0]  auth_code_q;
  logic [7:0]  origin_code_q;
  logic [15:0] min_len_q;

  // Always take writes; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auth_code_q   <= thp_pkg::AuthTypeReset;
      origin_code_q <= thp_pkg::OriginTypeReset;
      min_len_q     <= thp_pkg::MinLenReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        thp_pkg::CfgAuthTypeCode:   auth_code_q   <= cfg_i.data[7:0];
        thp_pkg::CfgOriginTypeCode: origin_code_q <= cfg_i.data[7:0];
        thp_pkg::CfgMinPacketLen:   min_len_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o.auth_type_code    = auth_code_q;
  assign cfg_o.origin_type_code  = origin_code_q;
  assign cfg_o.min_packet_length = min_len_q;

endmodule

// ----- rtl/thp_byte_stage.sv -----
// Input register of the Teredo header parser: holds one byte item for the core.
// Depends on thp_pkg and thp_byte_if.
module thp_byte_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  thp_byte_if.sink              byte_i,
  input  logic                  take_i,
  output thp_pkg::byte_item_t   item_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;

  // Refill whenever empty or the held item moves on this cycle
  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= byte_i.data_byte;
      last_q <= byte_i.last_byte;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;
  assign item_o.last  = last_q;

endmodule

// ----- rtl/thp_parse_core.sv -----
// Parse state and verdict register of the Teredo header parser.
// Depends on thp_pkg and thp_result_if.
module thp_parse_core #(
  parameter int unsigned MaxPacketBytes = thp_pkg::MaxPacketBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  thp_pkg::cfg_t        cfg_i,
  input  thp_pkg::byte_item_t  item_i,
  output logic                 take_o,
  thp_result_if.source         result_o
);

  localparam logic [3:0] PhFirst0  = 4'd0;
  localparam logic [3:0] PhFirst1  = 4'd1;
  localparam logic [3:0] PhIdLen   = 4'd2;
  localparam logic [3:0] PhAuLen   = 4'd3;
  localparam logic [3:0] PhSkip    = 4'd4;
  localparam logic [3:0] PhNonce   = 4'd5;
  localparam logic [3:0] PhOrig0   = 4'd6;
  localparam logic [3:0] PhOrig1   = 4'd7;
  localparam logic [3:0] PhOrig    = 4'd8;
  localparam logic [3:0] PhPayload = 4'd9;

  localparam logic [15:0] MaxBytes    = 16'(MaxPacketBytes);
  localparam logic [9:0]  AuthFixed   = 10'(thp_pkg::AuthFixedBytes);
  localparam logic [8:0]  NonceCount  = 9'(thp_pkg::NonceConfirmBytes);
  localparam logic [8:0]  OriginSkip  = 9'(thp_pkg::OriginBytes - 2);
  localparam logic [9:0]  OriginLen   = 10'(thp_pkg::OriginBytes);

  // Per-datagram state
  logic [15:0] pos_q, pos_d;
  logic [3:0]  phase_q, phase_d;
  logic [8:0]  skip_q, skip_d;
  logic [7:0]  held_q, held_d;
  logic [63:0] nonce_q, nonce_d;
  logic [7:0]  confirm_q, confirm_d;
  logic [47:0] origin_q, origin_d;
  logic [1:0]  flags_q, flags_d;
  logic [9:0]  hdr_end_q, hdr_end_d;

  // Verdict register
  logic        out_valid_q;
  logic        status_q, auth_q, orig_q;
  logic [63:0] out_nonce_q;
  logic [7:0]  out_confirm_q;
  logic [15:0] out_port_q;
  logic [31:0] out_addr_q;
  logic [9:0]  out_offset_q;
  logic [15:0] out_length_q;

  logic [8:0]  skip_sum;
  logic [7:0]  b;
  logic        auth, orig, reject;
  logic [9:0]  hdr_ptr, pay_ptr;
  logic        out_free;

  assign b = item_i.data;

  // A non-final byte always moves; a final one needs the verdict slot
  assign out_free = !out_valid_q || result_o.ready;
  assign take_o   = item_i.valid && (!item_i.last || out_free);

  // Next parse state for the held byte
  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    skip_d    = skip_q;
    held_d    = held_q;
    nonce_d   = nonce_q;
    confirm_d = confirm_q;
    origin_d  = origin_q;
    flags_d   = flags_q;
    hdr_end_d = hdr_end_q;
    skip_sum  = skip_q + {1'b0, b};
    if (pos_q < MaxBytes) begin
      pos_d = pos_q + 16'd1;
      unique case (phase_q)
        PhFirst0: begin
          held_d  = b;
          phase_d = PhFirst1;
        end
        PhFirst1: begin
          if (held_q == 8'd0 && b == cfg_i.auth_type_code) begin
            flags_d[0] = 1'b1;
            hdr_end_d  = AuthFixed;
            phase_d    = PhIdLen;
          end else if (held_q == 8'd0 && b == cfg_i.origin_type_code) begin
            flags_d[1] = 1'b1;
            skip_d     = OriginSkip;
            phase_d    = PhOrig;
          end else begin
            phase_d = PhPayload;
          end
        end
        PhIdLen: begin
          skip_d  = {1'b0, b};
          phase_d = PhAuLen;
        end
        PhAuLen: begin
          hdr_end_d = AuthFixed + {1'b0, skip_sum};
          if (skip_sum == 9'd0) begin
            skip_d  = NonceCount;
            phase_d = PhNonce;
          end else begin
            skip_d  = skip_sum;
            phase_d = PhSkip;
          end
        end
        PhSkip: begin
          skip_d = skip_q - 9'd1;
          if (skip_d == 9'd0) begin
            skip_d  = NonceCount;
            phase_d = PhNonce;
          end
        end
        PhNonce: begin
          if (skip_q > 9'd1) begin
            nonce_d = {nonce_q[55:0], b};
          end else begin
            confirm_d = b;
          end
          skip_d = skip_q - 9'd1;
          if (skip_d == 9'd0) begin
            phase_d = PhOrig0;
          end
        end
        PhOrig0: begin
          held_d  = b;
          phase_d = PhOrig1;
        end
        PhOrig1: begin
          if (held_q == 8'd0 && b == cfg_i.origin_type_code) begin
            flags_d[1] = 1'b1;
            skip_d     = OriginSkip;
            phase_d    = PhOrig;
          end else begin
            phase_d = PhPayload;
          end
        end
        PhOrig: begin
          origin_d = {origin_q[39:0], b};
          skip_d   = skip_q - 9'd1;
          if (skip_d == 9'd0) begin
            phase_d = PhPayload;
          end
        end
        default: ;
      endcase
    end
  end

  // Verdict from the state that includes the final byte
  always_comb begin
    auth    = flags_d[0];
    orig    = flags_d[1];
    hdr_ptr = auth ? hdr_end_d : 10'd0;
    pay_ptr = orig ? hdr_ptr + OriginLen : hdr_ptr;
    reject  = pos_d < cfg_i.min_packet_length;
    if (auth && pos_d < {6'd0, hdr_end_d}) begin
      reject = 1'b1;
    end
    if (orig && pos_d < {6'd0, pay_ptr}) begin
      reject = 1'b1;
    end
  end

  // Advance the parse state; clear it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PhFirst0;
      skip_q    <= '0;
      held_q    <= '0;
      nonce_q   <= '0;
      confirm_q <= '0;
      origin_q  <= '0;
      flags_q   <= '0;
      hdr_end_q <= '0;
    end else if (take_o) begin
      if (item_i.last) begin
        pos_q     <= '0;
        phase_q   <= PhFirst0;
        skip_q    <= '0;
        held_q    <= '0;
        nonce_q   <= '0;
        confirm_q <= '0;
        origin_q  <= '0;
        flags_q   <= '0;
        hdr_end_q <= '0;
      end else begin
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        skip_q    <= skip_d;
        held_q    <= held_d;
        nonce_q   <= nonce_d;
        confirm_q <= confirm_d;
        origin_q  <= origin_d;
        flags_q   <= flags_d;
        hdr_end_q <= hdr_end_d;
      end
    end
  end

  // Hold the verdict until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load verdict fields; a rejected datagram sets status and reports zeros elsewhere
  always_ff @(posedge clk_i) begin
    if (take_o && item_i.last) begin
      status_q      <= reject;
      auth_q        <= !reject && auth;
      orig_q        <= !reject && orig;
      out_nonce_q   <= (!reject && auth) ? nonce_d : 64'd0;
      out_confirm_q <= (!reject && auth) ? confirm_d : 8'd0;
      out_port_q    <= (!reject && orig) ? origin_d[47:32] : 16'd0;
      out_addr_q    <= (!reject && orig) ? origin_d[31:0] : 32'd0;
      out_offset_q  <= reject ? 10'd0 : pay_ptr;
      out_length_q  <= reject ? 16'd0 : pos_d - {6'd0, pay_ptr};
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.status          = status_q;
  assign result_o.auth_present    = auth_q;
  assign result_o.origin_present  = orig_q;
  assign result_o.nonce_value     = out_nonce_q;
  assign result_o.confirm_byte    = out_confirm_q;
  assign result_o.origin_port_raw = out_port_q;
  assign result_o.origin_addr_raw = out_addr_q;
  assign result_o.payload_offset  = out_offset_q;
  assign result_o.payload_length  = out_length_q;

endmodule

// ----- rtl/teredo_header_parser.sv -----
// Top level of the Teredo header parser.
// Depends on thp_pkg, the interfaces in thp_if, thp_cfg_regs, thp_byte_stage, thp_parse_core.
//
// Usage:
//   byte_i   : one datagram byte per item, last_byte set on the final byte.
//   result_o : one verdict item per datagram, produced from its final byte.
//   cfg_i    : register writes (0 auth type code, 1 origin type code,
//              2 minimum datagram length); ready is always high. Write only
//              while no datagram is in flight.
// Timing: a byte is held in the input register until the core takes it and uses
//   it to update the parse state; the verdict is loaded into the result register
//   when the core takes the final byte. One byte is accepted per cycle, except
//   while a final byte waits for the verdict register to be free.
// Stall: a waiting verdict does not block bytes of the next datagram; only
//   its final byte waits until the verdict register is free.
// Reset: clears the parse state and both valid flags and loads the register
//   reset values (auth type 1, origin type 0, minimum length 40); no datagram
//   is in flight afterward.
module teredo_header_parser #(
  parameter int unsigned MaxPacketBytes = thp_pkg::MaxPacketBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  thp_byte_if.sink      byte_i,
  thp_result_if.source  result_o,
  thp_cfg_if.sink       cfg_i
);

  thp_pkg::cfg_t       cfg;
  thp_pkg::byte_item_t item;
  logic                take;

  thp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  thp_byte_stage u_byte_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .take_i (take),
    .item_o (item)
  );

  thp_parse_core #(
    .MaxPacketBytes (MaxPacketBytes)
  ) u_parse_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item),
    .take_o   (take),
    .result_o (result_o)
  );

endmodule

// ----- dv/testbench.sv -----
// Testbench for teredo_header_parser: random and directed datagrams, checked against
// a cycle-free predictor of the verdicts. Depends on thp_pkg, the thp_if interfaces
// and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned ItemBudget = 1400;

  typedef enum logic [3:0] {
    P_LEAD, P_TYPE, P_ID_LEN, P_AUTH_LEN, P_SKIP,
    P_NONCE, P_ORIG_LEAD, P_ORIG_TYPE, P_ORIGIN, P_PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    logic        status;
    logic        auth_present;
    logic        origin_present;
    logic [63:0] nonce_value;
    logic [7:0]  confirm_byte;
    logic [15:0] origin_port_raw;
    logic [31:0] origin_addr_raw;
    logic [9:0]  payload_offset;
    logic [15:0] payload_length;
  } verdict_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
  } byte_slot_t;

  logic clk_i;
  logic rst_ni;

  thp_byte_if   byte_ch ();
  thp_result_if verdict_ch ();
  thp_cfg_if    cfg_ch ();

  teredo_header_parser u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (verdict_ch),
    .cfg_i    (cfg_ch)
  );

  // Bytes waiting to be offered, and verdicts waiting to arrive
  byte_slot_t  pending_bytes[$];
  verdict_t    verdicts_due[$];
  byte_slot_t  cur_slot = '{data: 8'h00, last: 1'b0, gap: 0};
  bit          have_cur = 1'b0;
  bit          offering = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_armed = 1'b1;
  bit          hold_go = 1'b0;
  bit          steady_tx = 1'b0;
  bit          steady_rx = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned bytes_queued = 0;

  // Register copies and the codes the generator builds headers with
  logic [7:0]  cfg_auth = thp_pkg::AuthTypeReset;
  logic [7:0]  cfg_origin = thp_pkg::OriginTypeReset;
  logic [15:0] cfg_min = thp_pkg::MinLenReset;
  logic [7:0]  gen_auth = thp_pkg::AuthTypeReset;
  logic [7:0]  gen_origin = thp_pkg::OriginTypeReset;

  // Parse state of the predictor
  logic [15:0]  pos_cnt = '0;
  parse_phase_e phase = P_LEAD;
  logic [8:0]   skip_cnt = '0;
  logic [7:0]   lead_byte = '0;
  logic [63:0]  nonce_acc = '0;
  logic [7:0]   confirm_acc = '0;
  logic [47:0]  origin_acc = '0;
  logic         auth_seen = 1'b0;
  logic         origin_seen = 1'b0;
  logic [9:0]   auth_end = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Advance the parse state by one byte; on the final byte queue the verdict
  task automatic track_byte(input logic [7:0] b, input logic last);
    verdict_t    v;
    int unsigned len;
    int unsigned ptr;
    logic        reject;
    if (pos_cnt < thp_pkg::MaxPacketBytes) begin
      case (phase)
        P_LEAD: begin
          lead_byte = b;
          phase = P_TYPE;
        end
        P_TYPE: begin
          if (lead_byte == 8'h00 && b == cfg_auth) begin
            auth_seen = 1'b1;
            auth_end = 10'(thp_pkg::AuthFixedBytes);
            phase = P_ID_LEN;
          end else if (lead_byte == 8'h00 && b == cfg_origin) begin
            origin_seen = 1'b1;
            skip_cnt = 9'(thp_pkg::OriginBytes - 2);
            phase = P_ORIGIN;
          end else begin
            phase = P_PAYLOAD;
          end
        end
        P_ID_LEN: begin
          skip_cnt = {1'b0, b};
          phase = P_AUTH_LEN;
        end
        P_AUTH_LEN: begin
          skip_cnt = skip_cnt + {1'b0, b};
          auth_end = 10'(thp_pkg::AuthFixedBytes + skip_cnt);
          if (skip_cnt == 0) begin
            skip_cnt = 9'(thp_pkg::NonceConfirmBytes);
            phase = P_NONCE;
          end else begin
            phase = P_SKIP;
          end
        end
        P_SKIP: begin
          skip_cnt--;
          if (skip_cnt == 0) begin
            skip_cnt = 9'(thp_pkg::NonceConfirmBytes);
            phase = P_NONCE;
          end
        end
        P_NONCE: begin
          if (skip_cnt > 1) nonce_acc = {nonce_acc[55:0], b};
          else confirm_acc = b;
          skip_cnt--;
          if (skip_cnt == 0) phase = P_ORIG_LEAD;
        end
        P_ORIG_LEAD: begin
          lead_byte = b;
          phase = P_ORIG_TYPE;
        end
        P_ORIG_TYPE: begin
          if (lead_byte == 8'h00 && b == cfg_origin) begin
            origin_seen = 1'b1;
            skip_cnt = 9'(thp_pkg::OriginBytes - 2);
            phase = P_ORIGIN;
          end else begin
            phase = P_PAYLOAD;
          end
        end
        P_ORIGIN: begin
          origin_acc = {origin_acc[39:0], b};
          skip_cnt--;
          if (skip_cnt == 0) phase = P_PAYLOAD;
        end
        default: ;
      endcase
      pos_cnt++;
    end
    if (last) begin
      len = {16'd0, pos_cnt};
      ptr = auth_seen ? {22'd0, auth_end} : 0;
      reject = len < {16'd0, cfg_min};
      if (auth_seen && len < {22'd0, auth_end}) reject = 1'b1;
      if (origin_seen) begin
        if (len < ptr + thp_pkg::OriginBytes) reject = 1'b1;
        ptr += thp_pkg::OriginBytes;
      end
      v = '0;
      if (reject) begin
        v.status = 1'b1;
      end else begin
        v.auth_present = auth_seen;
        v.origin_present = origin_seen;
        if (auth_seen) begin
          v.nonce_value = nonce_acc;
          v.confirm_byte = confirm_acc;
        end
        if (origin_seen) begin
          v.origin_port_raw = origin_acc[47:32];
          v.origin_addr_raw = origin_acc[31:0];
        end
        v.payload_offset = ptr[9:0];
        v.payload_length = 16'(len - ptr);
      end
      verdicts_due.push_back(v);
      // Drop all per-datagram state
      pos_cnt = '0;
      phase = P_LEAD;
      skip_cnt = '0;
      lead_byte = '0;
      nonce_acc = '0;
      confirm_acc = '0;
      origin_acc = '0;
      auth_seen = 1'b0;
      origin_seen = 1'b0;
      auth_end = '0;
    end
  endtask

  // Byte driver: retire the accepted item, then fetch and offer the next after its gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (offering && byte_ch.ready) begin
        track_byte(cur_slot.data, cur_slot.last);
        offering = 1'b0;
        have_cur = 1'b0;
      end
      if (!have_cur && pending_bytes.size() > 0) begin
        cur_slot = pending_bytes.pop_front();
        gap_left = cur_slot.gap;
        have_cur = 1'b1;
      end
      if (have_cur && !offering) begin
        if (gap_left == 0) offering = 1'b1;
        else gap_left--;
      end
      byte_ch.valid <= offering;
      byte_ch.data_byte <= cur_slot.data;
      byte_ch.last_byte <= cur_slot.last;
    end
  end

  // Long receiver hold-off, started once on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go && hold_armed) begin
      hold_left <= LongHold;
      hold_armed <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Verdict monitor: compare each accepted verdict with the oldest one due
  always @(posedge clk_i) begin : verdict_mon
    verdict_t seen;
    verdict_t want;
    if (!rst_ni) begin
      verdict_ch.ready <= 1'b0;
    end else begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        seen.status = verdict_ch.status;
        seen.auth_present = verdict_ch.auth_present;
        seen.origin_present = verdict_ch.origin_present;
        seen.nonce_value = verdict_ch.nonce_value;
        seen.confirm_byte = verdict_ch.confirm_byte;
        seen.origin_port_raw = verdict_ch.origin_port_raw;
        seen.origin_addr_raw = verdict_ch.origin_addr_raw;
        seen.payload_offset = verdict_ch.payload_offset;
        seen.payload_length = verdict_ch.payload_length;
        if (verdicts_due.size() == 0) begin
          report_mismatch("verdict arrived with none due");
        end else begin
          want = verdicts_due.pop_front();
          check_field("status", 64'(seen.status), 64'(want.status));
          check_field("auth_present", 64'(seen.auth_present), 64'(want.auth_present));
          check_field("origin_present", 64'(seen.origin_present), 64'(want.origin_present));
          check_field("nonce_value", seen.nonce_value, want.nonce_value);
          check_field("confirm_byte", 64'(seen.confirm_byte), 64'(want.confirm_byte));
          check_field("origin_port_raw", 64'(seen.origin_port_raw),
                      64'(want.origin_port_raw));
          check_field("origin_addr_raw", 64'(seen.origin_addr_raw),
                      64'(want.origin_addr_raw));
          check_field("payload_offset", 64'(seen.payload_offset), 64'(want.payload_offset));
          check_field("payload_length", 64'(seen.payload_length), 64'(want.payload_length));
        end
        stall_left = steady_rx ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      verdict_ch.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      thp_pkg::CfgAuthTypeCode:   cfg_auth = val[7:0];
      thp_pkg::CfgOriginTypeCode: cfg_origin = val[7:0];
      thp_pkg::CfgMinPacketLen:   cfg_min = val;
      default: ;
    endcase
  endtask

  // Write all three registers; upper bits of the 8-bit codes carry noise
  task automatic program_regs(input logic [7:0] auth_code, input logic [7:0] orig_code,
                              input logic [15:0] min_len);
    write_reg(thp_pkg::CfgAuthTypeCode, {8'($urandom), auth_code});
    write_reg(thp_pkg::CfgOriginTypeCode, {8'($urandom), orig_code});
    write_reg(thp_pkg::CfgMinPacketLen, min_len);
    cfg_ch.valid <= 1'b0;
    gen_auth = auth_code;
    gen_origin = orig_code;
  endtask

  // Hold until every byte is taken and every verdict has come, then let the block settle
  task automatic wait_quiet();
    while (pending_bytes.size() > 0 || have_cur || verdicts_due.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] fill_byte(input int fill);
    return (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
  endfunction

  // Assemble a datagram: optional authentication header, optional origin, then tail bytes
  task automatic build_datagram(output logic [7:0] dg[$], input bit with_auth,
                                input bit with_origin, input int id_len, input int au_len,
                                input int tail_len, input int fill);
    dg = {};
    if (with_auth) begin
      dg.push_back(8'h00);
      dg.push_back(gen_auth);
      dg.push_back(8'(id_len));
      dg.push_back(8'(au_len));
      repeat (id_len + au_len + thp_pkg::NonceConfirmBytes) dg.push_back(fill_byte(fill));
    end
    if (with_origin) begin
      dg.push_back(8'h00);
      dg.push_back(gen_origin);
      repeat (thp_pkg::OriginBytes - 2) dg.push_back(fill_byte(fill));
    end
    repeat (tail_len) dg.push_back(fill_byte(fill));
  endtask

  task automatic send_datagram(input logic [7:0] dg[$]);
    byte_slot_t slot;
    foreach (dg[i]) begin
      slot.data = dg[i];
      slot.last = (i == dg.size() - 1);
      slot.gap = steady_tx ? 0 : $urandom_range(0, 9);
      pending_bytes.push_back(slot);
    end
    bytes_queued += dg.size();
  endtask

  task automatic truncate(ref logic [7:0] dg[$], input int keep);
    while (dg.size() > keep) void'(dg.pop_back());
  endtask

  // One random datagram: mostly well-formed headers with random content, some noise
  task automatic send_random_datagram();
    logic [7:0] dg[$];
    int         kind;
    int         id_len;
    int         au_len;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 9) == 0) begin
      id_len = $urandom_range(0, 255);
      au_len = $urandom_range(0, 255);
    end else begin
      id_len = $urandom_range(0, 6);
      au_len = $urandom_range(0, 6);
    end
    if (kind <= 5)
      build_datagram(dg, 1'b1, 1'($urandom_range(0, 1)), id_len, au_len,
                     $urandom_range(0, 40), -1);
    else if (kind <= 7)
      build_datagram(dg, 1'b0, 1'b1, 0, 0, $urandom_range(0, 40), -1);
    else
      build_datagram(dg, 1'b0, 1'b0, 0, 0, $urandom_range(1, 60), -1);
    if ($urandom_range(0, 4) == 0) truncate(dg, $urandom_range(1, dg.size()));
    send_datagram(dg);
  endtask

  initial begin : stimulus
    logic [7:0] dg[$];
    logic [7:0] code;
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    verdict_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = thp_pkg::CfgAuthTypeCode;
    cfg_ch.data = 16'h0000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: plain, short, origin-only and full-header datagrams
    build_datagram(dg, 1'b0, 1'b0, 0, 0, 40, 255);
    send_datagram(dg);
    build_datagram(dg, 1'b0, 1'b0, 0, 0, 39, 0);
    send_datagram(dg);
    build_datagram(dg, 1'b0, 1'b0, 0, 0, 40, 0);
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b1, 0, 0, 20, -1);
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b1, 255, 255, 10, -1);
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b0, 100, 0, 0, -1);
    truncate(dg, 50);
    send_datagram(dg);
    wait_quiet();

    // Equal type codes with no length floor: authentication wins
    program_regs(8'h00, 8'h00, 16'h0000);
    dg = {8'h00};
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b0, 0, 0, 0, -1);
    truncate(dg, 2);
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b0, 3, 2, 0, -1);
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b0, 3, 2, 1, 0);
    send_datagram(dg);
    wait_quiet();

    // Top authentication code: short origin, exact origin, all-ones fields
    program_regs(8'hFF, 8'h00, 16'h0000);
    build_datagram(dg, 1'b0, 1'b1, 0, 0, 0, -1);
    truncate(dg, 5);
    send_datagram(dg);
    build_datagram(dg, 1'b0, 1'b1, 0, 0, 0, 255);
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b1, 0, 0, 3, 255);
    send_datagram(dg);
    build_datagram(dg, 1'b1, 1'b1, 1, 1, 0, -1);
    truncate(dg, 20);
    send_datagram(dg);
    wait_quiet();

    // Highest length floor: every datagram falls short
    program_regs(8'h07, 8'h09, 16'hFFFF);
    build_datagram(dg, 1'b1, 1'b1, 4, 4, 20, -1);
    send_datagram(dg);
    build_datagram(dg, 1'b0, 1'b0, 0, 0, 100, -1);
    send_datagram(dg);
    wait_quiet();

    // Receiver holds off while short datagrams stream in back to back
    program_regs(8'h01, 8'h00, 16'h0000);
    steady_tx = 1'b1;
    hold_go <= 1'b1;
    repeat (12) begin
      build_datagram(dg, 1'b0, 1'b0, 0, 0, $urandom_range(1, 10), -1);
      send_datagram(dg);
    end
    wait_quiet();
    steady_tx = 1'b0;

    // Random phases with fresh register settings between them
    while (bytes_queued < ItemBudget) begin
      code = 8'($urandom_range(0, 255));
      program_regs(code, ($urandom_range(0, 4) == 0) ? code : 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 60)));
      steady_tx = ($urandom_range(0, 3) == 0);
      steady_rx = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 8)) begin
        if (bytes_queued < ItemBudget) send_random_datagram();
      end
      wait_quiet();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/thp_pkg.sv
rtl/thp_if.sv
rtl/thp_cfg_regs.sv
rtl/thp_byte_stage.sv
rtl/thp_parse_core.sv
rtl/teredo_header_parser.sv
dv/testbench.sv
